### rtl/lam_pkg.sv
// Package for the LED pattern animator: payload structs, pattern codes,
// controller states and per-pattern constant tables.
// No dependencies; used by every file under rtl/.
package lam_pkg;

  localparam int MAX_LEDS = 16;
  localparam int MASK_W   = 16;
  localparam int DIV_W    = 32;   // dividend / quotient width of the divider
  localparam int DVS_W    = 10;   // divisor / remainder width of the divider

  localparam logic [5:0]  FRAME_MS     = 6'd33;
  localparam logic [31:0] NOTE_TIMEOUT = 32'd1400;
  localparam logic [31:0] LINK_TIMEOUT = 32'd2200;
  localparam logic [7:0]  HELD_RESET   = 8'd50;
  localparam logic [4:0]  LED_CNT_RESET = 5'd8;
  localparam logic [7:0]  DEF_BRT_RESET = 8'd50;
  localparam logic [9:0]  BLINK_HALF   = 10'd350;

  localparam logic [23:0] COLOR_BLACK = 24'h000000;
  localparam logic [23:0] COLOR_CONN  = 24'h0078FF;
  localparam logic [23:0] COLOR_DISC  = 24'hFF1400;
  localparam logic [23:0] COLOR_NOTE  = 24'hFFDC78;
  localparam logic [23:0] COLOR_CALL  = 24'h00B4FF;
  localparam logic [23:0] COLOR_NAV   = 24'hFF9600;

  // Input kinds
  localparam logic [2:0] KIND_TICK  = 3'd0;
  localparam logic [2:0] KIND_CONN  = 3'd1;
  localparam logic [2:0] KIND_NOTE  = 3'd2;
  localparam logic [2:0] KIND_CALL  = 3'd3;
  localparam logic [2:0] KIND_NAV   = 3'd4;
  localparam logic [2:0] KIND_CLEAR = 3'd5;

  // Navigation directions
  localparam logic [2:0] DIR_LEFT   = 3'd1;
  localparam logic [2:0] DIR_RIGHT  = 3'd2;
  localparam logic [2:0] DIR_UTURN  = 3'd3;
  localparam logic [2:0] DIR_ROUND  = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] CFG_LED_COUNT  = 2'd0;
  localparam logic [1:0] CFG_DEF_BRIGHT = 2'd1;
  localparam logic [1:0] CFG_ENABLE     = 2'd2;

  typedef enum logic [3:0] {
    PAT_IDLE   = 4'd0,
    PAT_CONN   = 4'd1,
    PAT_DISC   = 4'd2,
    PAT_NOTE   = 4'd3,
    PAT_CALL   = 4'd4,
    PAT_NSTR   = 4'd5,
    PAT_NLEFT  = 4'd6,
    PAT_NRIGHT = 4'd7,
    PAT_NUTURN = 4'd8,
    PAT_NROUND = 4'd9
  } pattern_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TIMEOUT,
    ST_MOD_GO,
    ST_MOD_WAIT,
    ST_MAP_GO,
    ST_MAP_WAIT,
    ST_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic [2:0] kind;
    logic       active;
    logic [2:0] direction;
  } event_t;

  typedef struct packed {
    logic [23:0] led_color;
    logic [7:0]  brightness;
    logic [15:0] lit_mask;
  } frame_t;

  typedef struct packed {
    logic accept;       // input transfer this cycle
    logic timeout_chk;  // apply pattern timeouts
    logic mod_start;    // start elapsed mod period
    logic cap_phase;    // latch remainder as phase
    logic map_start;    // start map() division
    logic cap_level;    // latch map() quotient
    logic frame_load;   // load output register
  } dp_cmd_t;

  typedef struct packed {
    logic frame_due;    // accepted item is a tick that emits a frame
    logic div_done;
    logic out_free;
  } dp_status_t;

  function automatic logic is_pulse(pattern_e p);
    return (p == PAT_CONN) || (p == PAT_NOTE) || (p == PAT_CALL) || (p == PAT_NROUND);
  endfunction

  function automatic logic is_nav(pattern_e p);
    return (p == PAT_NSTR) || (p == PAT_NLEFT) || (p == PAT_NRIGHT) || (p == PAT_NUTURN);
  endfunction

  function automatic logic [DVS_W-1:0] pat_period(pattern_e p);
    logic [DVS_W-1:0] r;
    unique case (p)
      PAT_CONN:   r = 10'd900;
      PAT_DISC:   r = 10'd700;
      PAT_NOTE:   r = 10'd360;
      PAT_CALL:   r = 10'd620;
      PAT_NROUND: r = 10'd800;
      default:    r = 10'd1;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] pat_lo(pattern_e p);
    logic [7:0] r;
    unique case (p)
      PAT_CONN:   r = 8'd4;
      PAT_NOTE:   r = 8'd6;
      PAT_CALL:   r = 8'd8;
      PAT_NROUND: r = 8'd5;
      default:    r = 8'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] pat_hi(pattern_e p);
    logic [7:0] r;
    unique case (p)
      PAT_CONN:   r = 8'd24;
      PAT_NOTE:   r = 8'd34;
      PAT_CALL:   r = 8'd42;
      PAT_NROUND: r = 8'd28;
      default:    r = 8'd0;
    endcase
    return r;
  endfunction

  function automatic logic [23:0] pat_color(pattern_e p);
    logic [23:0] r;
    unique case (p)
      PAT_CONN:   r = COLOR_CONN;
      PAT_DISC:   r = COLOR_DISC;
      PAT_NOTE:   r = COLOR_NOTE;
      PAT_CALL:   r = COLOR_CALL;
      PAT_NSTR, PAT_NLEFT, PAT_NRIGHT, PAT_NUTURN, PAT_NROUND: r = COLOR_NAV;
      default:    r = COLOR_BLACK;
    endcase
    return r;
  endfunction

  // LEDs lit by the arrow patterns, before clipping to the driven count
  function automatic logic [MASK_W-1:0] nav_range(pattern_e p);
    logic [MASK_W-1:0] r;
    unique case (p)
      PAT_NSTR:   r = 16'h0007;
      PAT_NLEFT:  r = 16'h00E0;
      PAT_NRIGHT: r = 16'h000E;
      PAT_NUTURN: r = 16'h00F0;
      default:    r = 16'hFFFF;
    endcase
    return r;
  endfunction

endpackage

### rtl/lam_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on lam_pkg for the operand widths.
module lam_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [lam_pkg::DIV_W-1:0]  dividend_i,
  input  logic [lam_pkg::DVS_W-1:0]  divisor_i,
  output logic                       done_o,
  output logic [lam_pkg::DIV_W-1:0]  quotient_o,
  output logic [lam_pkg::DVS_W-1:0]  remainder_o
);

  localparam int CNT_W = $clog2(lam_pkg::DIV_W);

  logic                      busy_q, busy_d;
  logic                      done_q, done_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic [lam_pkg::DIV_W-1:0] dvd_q, dvd_d;
  logic [lam_pkg::DVS_W-1:0] rem_q, rem_d;
  logic [lam_pkg::DVS_W-1:0] dvs_q, dvs_d;
  logic [lam_pkg::DVS_W:0]   trial;
  logic                      fits;

  assign trial = {rem_q, dvd_q[lam_pkg::DIV_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(lam_pkg::DIV_W - 1);
      dvd_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      // dividend register shifts out on top and collects quotient bits below
      dvd_d = {dvd_q[lam_pkg::DIV_W-2:0], fits};
      rem_d = fits ? lam_pkg::DVS_W'(trial - {1'b0, dvs_q}) : trial[lam_pkg::DVS_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = dvd_q;
  assign remainder_o = rem_q;

endmodule

### rtl/lam_datapath.sv
// Datapath: configuration registers, pattern state and timers, the shared
// divider, frame rendering and the output register. Uses lam_pkg, lam_div.
module lam_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [7:0]          cfg_data_i,
  input  lam_pkg::event_t     in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lam_pkg::frame_t     out_data_o,
  input  lam_pkg::dp_cmd_t    cmd_i,
  output lam_pkg::dp_status_t status_o
);

  logic [4:0]  led_count_q;
  logic [7:0]  def_bright_q;
  logic        enable_q;

  lam_pkg::pattern_e pattern_q, pattern_d;
  logic [31:0]       elapsed_q, elapsed_d;
  logic [5:0]        frame_ms_q, frame_ms_d;
  logic [7:0]        held_q, held_d;
  logic [lam_pkg::DVS_W-1:0] phase_q;
  logic [7:0]        quo_q;
  logic              out_valid_q, out_valid_d;
  lam_pkg::frame_t   out_q, out_d;

  lam_pkg::pattern_e sel_pat;
  logic              sel_en;

  // shared divider
  logic                      div_start, div_done;
  logic [lam_pkg::DIV_W-1:0] div_dividend, div_quo;
  logic [lam_pkg::DVS_W-1:0] div_divisor, div_rem;
  logic [lam_pkg::DVS_W-1:0] period, half, ph_off;
  logic [7:0]                lo, hi, diff, level;
  logic [17:0]               prod;
  logic                      rising;

  logic [6:0]                drv_cnt;
  logic [lam_pkg::MASK_W-1:0] all_mask;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_count_q  <= lam_pkg::LED_CNT_RESET;
      def_bright_q <= lam_pkg::DEF_BRT_RESET;
      enable_q     <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        lam_pkg::CFG_LED_COUNT:  led_count_q  <= cfg_data_i[4:0];
        lam_pkg::CFG_DEF_BRIGHT: def_bright_q <= cfg_data_i;
        lam_pkg::CFG_ENABLE:     enable_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // pattern requested by an event
  always_comb begin
    sel_pat = lam_pkg::PAT_IDLE;
    sel_en  = 1'b0;
    unique case (in_data_i.kind)
      lam_pkg::KIND_CONN: begin
        sel_en  = 1'b1;
        sel_pat = in_data_i.active ? lam_pkg::PAT_CONN : lam_pkg::PAT_DISC;
      end
      lam_pkg::KIND_NOTE: begin
        sel_en  = (pattern_q != lam_pkg::PAT_CALL);
        sel_pat = lam_pkg::PAT_NOTE;
      end
      lam_pkg::KIND_CALL: begin
        sel_en  = 1'b1;
        sel_pat = in_data_i.active ? lam_pkg::PAT_CALL : lam_pkg::PAT_IDLE;
      end
      lam_pkg::KIND_NAV: begin
        sel_en = 1'b1;
        if (!in_data_i.active) begin
          sel_pat = lam_pkg::PAT_IDLE;
        end else begin
          unique case (in_data_i.direction)
            lam_pkg::DIR_LEFT:  sel_pat = lam_pkg::PAT_NLEFT;
            lam_pkg::DIR_RIGHT: sel_pat = lam_pkg::PAT_NRIGHT;
            lam_pkg::DIR_UTURN: sel_pat = lam_pkg::PAT_NUTURN;
            lam_pkg::DIR_ROUND: sel_pat = lam_pkg::PAT_NROUND;
            default:            sel_pat = lam_pkg::PAT_NSTR;
          endcase
        end
      end
      lam_pkg::KIND_CLEAR: begin
        sel_en  = 1'b1;
        sel_pat = lam_pkg::PAT_IDLE;
      end
      default: ;
    endcase
  end

  // an enabled tick emits a frame when the saturated counter reaches 33 after its step
  assign status_o.frame_due = (in_data_i.kind == lam_pkg::KIND_TICK) && enable_q &&
                              (frame_ms_q >= lam_pkg::FRAME_MS - 6'd1);
  assign status_o.div_done  = div_done;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  // pulse arithmetic
  assign period = lam_pkg::pat_period(pattern_q);
  assign half   = period >> 1;
  assign lo     = lam_pkg::pat_lo(pattern_q);
  assign hi     = lam_pkg::pat_hi(pattern_q);
  assign diff   = hi - lo;
  assign rising = phase_q < half;
  assign ph_off = rising ? phase_q : phase_q - half;
  assign prod   = 18'(ph_off) * 18'(diff);
  // truncation toward zero on the falling side equals hi minus the magnitude
  assign level  = rising ? lo + quo_q : hi - quo_q;

  assign div_start    = cmd_i.mod_start || cmd_i.map_start;
  assign div_dividend = cmd_i.mod_start ? elapsed_q : lam_pkg::DIV_W'(prod);
  assign div_divisor  = cmd_i.mod_start ? period : half;

  lam_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // driven LEDs
  assign drv_cnt = ({2'b0, led_count_q} > 7'(lam_pkg::MAX_LEDS)) ?
                   7'(lam_pkg::MAX_LEDS) : {2'b0, led_count_q};
  always_comb begin
    for (int i = 0; i < lam_pkg::MASK_W; i++) begin
      all_mask[i] = 7'(i) < drv_cnt;
    end
  end

  // state updates
  always_comb begin
    pattern_d  = pattern_q;
    elapsed_d  = elapsed_q;
    frame_ms_d = frame_ms_q;
    held_d     = held_q;
    if (cmd_i.accept) begin
      if (in_data_i.kind == lam_pkg::KIND_TICK) begin
        elapsed_d = elapsed_q + 32'd1;
        if (frame_ms_q < lam_pkg::FRAME_MS) begin
          frame_ms_d = frame_ms_q + 6'd1;
        end
        if (status_o.frame_due) begin
          frame_ms_d = '0;
        end
      end else if (sel_en && (sel_pat != pattern_q)) begin
        pattern_d  = sel_pat;
        elapsed_d  = '0;
        frame_ms_d = lam_pkg::FRAME_MS;
      end
    end
    if (cmd_i.timeout_chk) begin
      if (((pattern_q == lam_pkg::PAT_NOTE) && (elapsed_q > lam_pkg::NOTE_TIMEOUT)) ||
          (((pattern_q == lam_pkg::PAT_CONN) || (pattern_q == lam_pkg::PAT_DISC)) &&
           (elapsed_q > lam_pkg::LINK_TIMEOUT))) begin
        pattern_d  = lam_pkg::PAT_IDLE;
        elapsed_d  = '0;
        frame_ms_d = lam_pkg::FRAME_MS;
      end
    end
    if (cmd_i.frame_load) begin
      if (lam_pkg::is_pulse(pattern_q)) begin
        held_d = level;
      end else if (lam_pkg::is_nav(pattern_q)) begin
        held_d = def_bright_q;
      end
    end
  end

  // frame rendering and output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.frame_load) begin
      out_valid_d      = 1'b1;
      out_d.brightness = held_d;
      out_d.lit_mask   = all_mask & lam_pkg::nav_range(pattern_q);
      if ((pattern_q == lam_pkg::PAT_DISC) && (phase_q >= lam_pkg::BLINK_HALF)) begin
        out_d.led_color = lam_pkg::COLOR_BLACK;
      end else begin
        out_d.led_color = lam_pkg::pat_color(pattern_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q   <= lam_pkg::PAT_IDLE;
      elapsed_q   <= '0;
      frame_ms_q  <= lam_pkg::FRAME_MS;
      held_q      <= lam_pkg::HELD_RESET;
      out_valid_q <= 1'b0;
    end else begin
      pattern_q   <= pattern_d;
      elapsed_q   <= elapsed_d;
      frame_ms_q  <= frame_ms_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (cmd_i.cap_phase) begin
      phase_q <= div_rem;
    end
    if (cmd_i.cap_level) begin
      quo_q <= div_quo[7:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### rtl/lam_ctrl.sv
// Controller state machine: sequences accept, timeout check, the two
// divisions and the frame load. Uses lam_pkg.
module lam_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lam_pkg::dp_status_t status_i,
  output lam_pkg::dp_cmd_t    cmd_o
);

  lam_pkg::ctrl_state_e state_q, state_d;
  logic                 xfer;

  assign in_ready_o = (state_q == lam_pkg::ST_IDLE);
  assign xfer       = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lam_pkg::ST_IDLE:     if (xfer && status_i.frame_due) state_d = lam_pkg::ST_TIMEOUT;
      lam_pkg::ST_TIMEOUT:  state_d = lam_pkg::ST_MOD_GO;
      lam_pkg::ST_MOD_GO:   state_d = lam_pkg::ST_MOD_WAIT;
      lam_pkg::ST_MOD_WAIT: if (status_i.div_done) state_d = lam_pkg::ST_MAP_GO;
      lam_pkg::ST_MAP_GO:   state_d = lam_pkg::ST_MAP_WAIT;
      lam_pkg::ST_MAP_WAIT: if (status_i.div_done) state_d = lam_pkg::ST_EMIT;
      lam_pkg::ST_EMIT:     if (status_i.out_free) state_d = lam_pkg::ST_IDLE;
      default:              state_d = lam_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o             = '0;
    cmd_o.accept      = xfer;
    cmd_o.timeout_chk = (state_q == lam_pkg::ST_TIMEOUT);
    cmd_o.mod_start   = (state_q == lam_pkg::ST_MOD_GO);
    cmd_o.cap_phase   = (state_q == lam_pkg::ST_MOD_WAIT) && status_i.div_done;
    cmd_o.map_start   = (state_q == lam_pkg::ST_MAP_GO);
    cmd_o.cap_level   = (state_q == lam_pkg::ST_MAP_WAIT) && status_i.div_done;
    cmd_o.frame_load  = (state_q == lam_pkg::ST_EMIT) && status_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lam_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/led_pattern_animator.sv
// LED strip pattern animator, top level.
// Input channel (in_valid_i/in_ready_o/in_data_i): one 1 ms tick or one
// event (connection, notification, call, navigation, clear) per transfer.
// Output channel (out_valid_o/out_ready_i/out_data_o): one frame with
// color, brightness and lit-LED mask, held in an output register.
// Config channel (cfg_*): writes led_count, default_brightness, enable;
// always ready, write only while no item is in flight.
// Events and ticks that emit no frame leave the controller idle, so the
// input stays ready for the next item. A tick that emits a frame holds
// off the next item until it is done: two passes of the shared
// one-bit-per-cycle divider (elapsed mod period, then the pulse map division)
// plus control steps; the frame is then loaded into the output register.
// A frame waiting in the output register does not block the input; only a
// second frame stalls, in its last step, until the receiver takes the first.
// Reset: idle pattern, elapsed time cleared, a frame due at the first enabled
// tick, led_count 8, default_brightness 50, strip disabled.
// Depends on lam_pkg, lam_ctrl, lam_datapath, lam_div.
module led_pattern_animator (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  lam_pkg::event_t in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output lam_pkg::frame_t out_data_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [1:0]      cfg_index_i,
  input  logic [7:0]      cfg_data_i
);

  lam_pkg::dp_cmd_t    cmd;
  lam_pkg::dp_status_t status;

  lam_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lam_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule
